FILE: hdl/trle_pkg.sv
// ----------------------------------------------------------------------------
// trle_pkg
// Shared types and constants of the TGA RLE pixel decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HEADER,
    PH_IDSKIP,
    PH_PACKET,
    PH_PIXEL
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RUN    = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ERR_NONE  = 3'd0,
    ERR_CMAP  = 3'd1,
    ERR_TYPE  = 3'd2,
    ERR_DEPTH = 3'd3,
    ERR_SIZE  = 3'd4
  } err_t;

  // header byte positions
  localparam logic [4:0] HDR_ID_LEN = 5'd0;
  localparam logic [4:0] HDR_CMAP   = 5'd1;
  localparam logic [4:0] HDR_TYPE   = 5'd2;
  localparam logic [4:0] HDR_W_LO   = 5'd12;
  localparam logic [4:0] HDR_W_HI   = 5'd13;
  localparam logic [4:0] HDR_H_LO   = 5'd14;
  localparam logic [4:0] HDR_H_HI   = 5'd15;
  localparam logic [4:0] HDR_DEPTH  = 5'd16;
  localparam logic [4:0] HDR_DESC   = 5'd17;

  localparam logic [7:0] TYPE_RAW = 8'd2;
  localparam logic [7:0] TYPE_RLE = 8'h0A;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;
  localparam logic [7:0] OPAQUE   = 8'd255;

  localparam int FIFO_DEPTH = 4;

  typedef struct packed {
    kind_t       kind;
    err_t        code;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  run_length;
    logic [31:0] start_index;
    logic [15:0] width;
    logic [15:0] height;
    logic        last;
  } result_t;

endpackage

FILE: hdl/trle_ifs.sv
// ----------------------------------------------------------------------------
// trle_ifs
// Byte request channel and result channel of the TGA RLE pixel decoder.
// ----------------------------------------------------------------------------
interface trle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_file;
  logic       final_byte;

  modport source (output valid, data_byte, start_of_file, final_byte, input ready);
  modport sink (input valid, data_byte, start_of_file, final_byte, output ready);
endinterface

interface trle_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [2:0]  error_code;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  run_length;
  logic [31:0] start_index;
  logic [15:0] img_width;
  logic [15:0] img_height;
  logic        last_of_image;

  modport source (
    output valid, result_kind, error_code, red, green, blue, alpha, run_length,
           start_index, img_width, img_height, last_of_image,
    input  ready
  );
  modport sink (
    input  valid, result_kind, error_code, red, green, blue, alpha, run_length,
           start_index, img_width, img_height, last_of_image,
    output ready
  );
endinterface

FILE: hdl/trle_parser.sv
// ----------------------------------------------------------------------------
// trle_parser
// Input register and one-pass parse step: header, ID skip, packet and pixel
// bytes. Emits up to two results per byte into the result queue.
// ----------------------------------------------------------------------------
module trle_parser (
  input  logic               clk,
  input  logic               rst,
  trle_byte_if.sink          byte_in,
  input  logic               room,
  output logic [1:0]         push_count,
  output trle_pkg::result_t  push0,
  output trle_pkg::result_t  push1
);

  // input register
  logic       held;
  logic [7:0] q_byte;
  logic       q_sof;
  logic       q_fin;
  logic       fire;

  // parse state
  trle_pkg::phase_t phase, phase_next;
  logic [4:0]  hdr_count, hdr_count_next;
  logic [7:0]  id_left, id_left_next;
  logic        rle_mode, rle_mode_next;
  logic        has_alpha, has_alpha_next;
  logic [15:0] width_reg, width_reg_next;
  logic [15:0] height_reg, height_reg_next;
  logic [31:0] pixels_left, pixels_left_next;
  logic [31:0] next_index, next_index_next;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [31:0] color_bytes, color_bytes_next;
  logic [1:0]  color_pos, color_pos_next;

  logic              main_valid;
  logic              fin_err;
  trle_pkg::result_t main_res;
  trle_pkg::result_t err_res;

  assign fire         = held && room;
  assign byte_in.ready = !held || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (byte_in.valid && byte_in.ready) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
    if (byte_in.valid && byte_in.ready) begin
      q_byte <= byte_in.data_byte;
      q_sof  <= byte_in.start_of_file;
      q_fin  <= byte_in.final_byte;
    end
  end

  always_comb begin
    logic [4:0]  hdr_i;
    logic [31:0] cb;
    logic [1:0]  pos1;
    logic [7:0]  want;
    logic [7:0]  run;
    phase_next         = phase;
    hdr_count_next     = hdr_count;
    id_left_next       = id_left;
    rle_mode_next      = rle_mode;
    has_alpha_next     = has_alpha;
    width_reg_next     = width_reg;
    height_reg_next    = height_reg;
    pixels_left_next   = pixels_left;
    next_index_next    = next_index;
    packet_left_next   = packet_left;
    packet_is_run_next = packet_is_run;
    color_bytes_next   = color_bytes;
    color_pos_next     = color_pos;
    main_valid         = 1'b0;
    main_res           = '0;
    fin_err            = 1'b0;
    hdr_i              = '0;
    cb                 = '0;
    pos1               = '0;
    want               = '0;
    run                = '0;

    if (fire) begin
      if (q_sof) begin
        phase_next         = trle_pkg::PH_HEADER;
        hdr_count_next     = '0;
        id_left_next       = '0;
        rle_mode_next      = 1'b0;
        has_alpha_next     = 1'b0;
        width_reg_next     = '0;
        height_reg_next    = '0;
        pixels_left_next   = '0;
        next_index_next    = '0;
        packet_left_next   = '0;
        packet_is_run_next = 1'b0;
        color_bytes_next   = '0;
        color_pos_next     = '0;
      end

      case (phase_next)
        trle_pkg::PH_HEADER: begin
          hdr_i = hdr_count_next;
          if (hdr_i == trle_pkg::HDR_ID_LEN) begin
            id_left_next = q_byte;
          end else if (hdr_i == trle_pkg::HDR_CMAP) begin
            if (q_byte != 8'd0) begin
              main_valid = 1'b1;
              main_res.kind = trle_pkg::KIND_ERROR;
              main_res.code = trle_pkg::ERR_CMAP;
              phase_next = trle_pkg::PH_IDLE;
            end
          end else if (hdr_i == trle_pkg::HDR_TYPE) begin
            if (q_byte == trle_pkg::TYPE_RAW) begin
              rle_mode_next = 1'b0;
            end else if (q_byte == trle_pkg::TYPE_RLE) begin
              rle_mode_next = 1'b1;
            end else begin
              main_valid = 1'b1;
              main_res.kind = trle_pkg::KIND_ERROR;
              main_res.code = trle_pkg::ERR_TYPE;
              phase_next = trle_pkg::PH_IDLE;
            end
          end else if (hdr_i == trle_pkg::HDR_W_LO) begin
            width_reg_next[7:0] = q_byte;
          end else if (hdr_i == trle_pkg::HDR_W_HI) begin
            width_reg_next[15:8] = q_byte;
          end else if (hdr_i == trle_pkg::HDR_H_LO) begin
            height_reg_next[7:0] = q_byte;
          end else if (hdr_i == trle_pkg::HDR_H_HI) begin
            height_reg_next[15:8] = q_byte;
          end else if (hdr_i == trle_pkg::HDR_DEPTH) begin
            if (q_byte == trle_pkg::DEPTH_24) begin
              has_alpha_next = 1'b0;
            end else if (q_byte == trle_pkg::DEPTH_32) begin
              has_alpha_next = 1'b1;
            end else begin
              main_valid = 1'b1;
              main_res.kind = trle_pkg::KIND_ERROR;
              main_res.code = trle_pkg::ERR_DEPTH;
              phase_next = trle_pkg::PH_IDLE;
            end
          end else if (hdr_i == trle_pkg::HDR_DESC) begin
            main_valid = 1'b1;
            if (width_reg_next == 16'd0 || height_reg_next == 16'd0) begin
              main_res.kind = trle_pkg::KIND_ERROR;
              main_res.code = trle_pkg::ERR_SIZE;
              phase_next = trle_pkg::PH_IDLE;
            end else begin
              main_res.kind      = trle_pkg::KIND_HEADER;
              main_res.width     = width_reg_next;
              main_res.height    = height_reg_next;
              pixels_left_next   = {16'd0, width_reg_next} * {16'd0, height_reg_next};
              next_index_next    = '0;
              color_bytes_next   = '0;
              color_pos_next     = '0;
              packet_left_next   = '0;
              packet_is_run_next = 1'b0;
              if (id_left_next != 8'd0) begin
                phase_next = trle_pkg::PH_IDSKIP;
              end else begin
                phase_next = rle_mode_next ? trle_pkg::PH_PACKET : trle_pkg::PH_PIXEL;
              end
            end
          end
          if (phase_next == trle_pkg::PH_HEADER) begin
            hdr_count_next = hdr_i + 5'd1;
          end
        end

        trle_pkg::PH_IDSKIP: begin
          id_left_next = id_left_next - 8'd1;
          if (id_left_next == 8'd0) begin
            phase_next = rle_mode_next ? trle_pkg::PH_PACKET : trle_pkg::PH_PIXEL;
          end
        end

        trle_pkg::PH_PACKET: begin
          packet_left_next   = {1'b0, q_byte[6:0]} + 8'd1;
          packet_is_run_next = q_byte[7];
          color_bytes_next   = '0;
          color_pos_next     = '0;
          phase_next         = trle_pkg::PH_PIXEL;
        end

        trle_pkg::PH_PIXEL: begin
          cb   = color_bytes_next | ({24'd0, q_byte} << {color_pos_next, 3'b000});
          pos1 = color_pos_next + 2'd1;
          if (pos1 == (has_alpha_next ? 2'd0 : 2'd3)) begin
            want = (rle_mode_next && packet_is_run_next) ? packet_left_next : 8'd1;
            run  = ({24'd0, want} < pixels_left_next) ? want : pixels_left_next[7:0];
            main_valid           = 1'b1;
            main_res.kind        = trle_pkg::KIND_RUN;
            main_res.red         = cb[23:16];
            main_res.green       = cb[15:8];
            main_res.blue        = cb[7:0];
            main_res.alpha       = has_alpha_next ? cb[31:24] : trle_pkg::OPAQUE;
            main_res.run_length  = run;
            main_res.start_index = next_index_next;
            next_index_next      = next_index_next + {24'd0, run};
            pixels_left_next     = pixels_left_next - {24'd0, run};
            main_res.last        = (pixels_left_next == 32'd0);
            color_bytes_next     = '0;
            color_pos_next       = '0;
            if (pixels_left_next == 32'd0) begin
              phase_next = trle_pkg::PH_IDLE;
            end else if (rle_mode_next) begin
              if (packet_is_run_next || packet_left_next <= 8'd1) begin
                packet_left_next = '0;
                phase_next       = trle_pkg::PH_PACKET;
              end else begin
                packet_left_next = packet_left_next - 8'd1;
              end
            end
          end else begin
            color_bytes_next = cb;
            color_pos_next   = pos1;
          end
        end

        default: begin
        end
      endcase

      // truncated file: error after any other result of this byte
      if (q_fin && phase_next != trle_pkg::PH_IDLE) begin
        fin_err    = 1'b1;
        phase_next = trle_pkg::PH_IDLE;
      end
    end
  end

  always_comb begin
    err_res      = '0;
    err_res.kind = trle_pkg::KIND_ERROR;
    err_res.code = trle_pkg::ERR_SIZE;
    push0        = main_valid ? main_res : err_res;
    push1        = err_res;
    push_count   = {1'b0, main_valid} + {1'b0, fin_err};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= trle_pkg::PH_IDLE;
      hdr_count     <= '0;
      id_left       <= '0;
      rle_mode      <= 1'b0;
      has_alpha     <= 1'b0;
      width_reg     <= '0;
      height_reg    <= '0;
      pixels_left   <= '0;
      next_index    <= '0;
      packet_left   <= '0;
      packet_is_run <= 1'b0;
      color_bytes   <= '0;
      color_pos     <= '0;
    end else begin
      phase         <= phase_next;
      hdr_count     <= hdr_count_next;
      id_left       <= id_left_next;
      rle_mode      <= rle_mode_next;
      has_alpha     <= has_alpha_next;
      width_reg     <= width_reg_next;
      height_reg    <= height_reg_next;
      pixels_left   <= pixels_left_next;
      next_index    <= next_index_next;
      packet_left   <= packet_left_next;
      packet_is_run <= packet_is_run_next;
      color_bytes   <= color_bytes_next;
      color_pos     <= color_pos_next;
    end
  end

  // a byte that already ended the parse with an error never adds a truncation error
  a_no_double_error: assert property (@(posedge clk) disable iff (rst)
    !(main_valid && main_res.kind == trle_pkg::KIND_ERROR && fin_err))
    else $error("truncation error after an error result");

  // any error result leaves the parser idle
  a_error_goes_idle: assert property (@(posedge clk) disable iff (rst)
    (fin_err || (main_valid && main_res.kind == trle_pkg::KIND_ERROR))
      |=> phase == trle_pkg::PH_IDLE)
    else $error("parser not idle after error");

  // a header result starts pixel data with the full pixel count
  a_header_count: assert property (@(posedge clk) disable iff (rst)
    (main_valid && main_res.kind == trle_pkg::KIND_HEADER)
      |=> pixels_left != 32'd0 || phase == trle_pkg::PH_IDLE)
    else $error("header result with no pixels to decode");

endmodule

FILE: hdl/trle_fifo.sv
// ----------------------------------------------------------------------------
// trle_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
module trle_fifo #(
  parameter int Depth = trle_pkg::FIFO_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [1:0]         push_count,
  input  trle_pkg::result_t  push0,
  input  trle_pkg::result_t  push1,
  output logic               room,
  trle_result_if.source      result_out
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  trle_pkg::result_t mem [Depth];
  logic [PtrW-1:0] wp, wp1, rp;
  logic [CntW-1:0] count;
  logic            pop;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign wp1  = ptr_inc(wp);
  assign room = (count <= CntW'(Depth - 2));
  assign pop  = result_out.valid && result_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (push_count == 2'd1) begin
        wp <= wp1;
      end else if (push_count == 2'd2) begin
        wp <= ptr_inc(wp1);
      end
      if (pop) begin
        rp <= ptr_inc(rp);
      end
      count <= count + CntW'(push_count) - CntW'(pop);
    end
    if (push_count != 2'd0) begin
      mem[wp] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wp1] <= push1;
    end
  end

  assign result_out.valid         = (count != '0);
  assign result_out.result_kind   = mem[rp].kind;
  assign result_out.error_code    = mem[rp].code;
  assign result_out.red           = mem[rp].red;
  assign result_out.green         = mem[rp].green;
  assign result_out.blue          = mem[rp].blue;
  assign result_out.alpha         = mem[rp].alpha;
  assign result_out.run_length    = mem[rp].run_length;
  assign result_out.start_index   = mem[rp].start_index;
  assign result_out.img_width     = mem[rp].width;
  assign result_out.img_height    = mem[rp].height;
  assign result_out.last_of_image = mem[rp].last;

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("result queue overflow");

  a_push_with_room: assert property (@(posedge clk) disable iff (rst)
    push_count != 2'd0 |-> room && push_count != 2'd3)
    else $error("push into full result queue");

endmodule

FILE: hdl/tga_rle_pixel_decoder.sv
// ----------------------------------------------------------------------------
// tga_rle_pixel_decoder
// TGA file byte stream in, header/error results and RGBA pixel runs out.
//
//   channel      dir  carries
//   byte_in      in   data_byte, start_of_file, final_byte
//   result_out   out  result_kind, error_code, red/green/blue/alpha,
//                     run_length, start_index, img_width/height, last_of_image
//
// One byte per cycle while the queue has room. A byte is parsed once it is
// held in the input register and the queue has room; its results (at most
// two) then enter the queue. Results wait in a FifoDepth-entry queue;
// byte_in.ready drops while a byte is held and fewer than two queue entries
// are free. Reset (synchronous) leaves the parser idle and the queue empty;
// bytes before a start_of_file are dropped.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder #(
  parameter int FifoDepth = trle_pkg::FIFO_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  trle_byte_if.sink     byte_in,
  trle_result_if.source result_out
);

  logic              room;
  logic [1:0]        push_count;
  trle_pkg::result_t push0;
  trle_pkg::result_t push1;

  trle_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .room       (room),
    .push_count (push_count),
    .push0      (push0),
    .push1      (push1)
  );

  trle_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (push0),
    .push1      (push1),
    .room       (room),
    .result_out (result_out)
  );

endmodule
